### hdl/kslp_pkg.sv
// Package for the keypad short/long press qualifier.
// Holds field widths, register indexes, reset values and the shared structs.
// No dependencies.
package kslp_pkg;

	localparam int KEY_W    = 4;
	localparam int LOW_W    = 5;
	localparam int HIGH_W   = 3;
	localparam int DEB_W    = 6;
	localparam int TPS_W    = 7;
	localparam int SEC_W    = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 7;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_TPS      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_LONG     = 2'd2;

	localparam logic [DEB_W-1:0] DEB_RESET = 6'd5;
	localparam logic [TPS_W-1:0] TPS_RESET = 7'd100;
	localparam logic [SEC_W-1:0] SEC_RESET = 4'd3;

	// Key codes
	localparam logic [KEY_W-1:0] KEY_NONE  = 4'd0;
	localparam logic [KEY_W-1:0] KEY_POWER = 4'd1;
	localparam logic [KEY_W-1:0] KEY_2     = 4'd2;
	localparam logic [KEY_W-1:0] KEY_3     = 4'd3;
	localparam logic [KEY_W-1:0] KEY_4     = 4'd4;
	localparam logic [KEY_W-1:0] KEY_5     = 4'd5;
	localparam logic [KEY_W-1:0] KEY_6     = 4'd6;
	localparam logic [KEY_W-1:0] KEY_7     = 4'd7;
	localparam logic [KEY_W-1:0] KEY_8     = 4'd8;

	// Active-low pin patterns
	localparam logic [LOW_W-1:0]  PAT_K1 = 5'h0f;
	localparam logic [LOW_W-1:0]  PAT_K2 = 5'h17;
	localparam logic [LOW_W-1:0]  PAT_K3 = 5'h1b;
	localparam logic [LOW_W-1:0]  PAT_K4 = 5'h1d;
	localparam logic [LOW_W-1:0]  PAT_K5 = 5'h1e;
	localparam logic [HIGH_W-1:0] PAT_K6 = 3'h3;
	localparam logic [HIGH_W-1:0] PAT_K7 = 3'h5;
	localparam logic [HIGH_W-1:0] PAT_K8 = 3'h6;

	typedef struct packed {
		logic [DEB_W-1:0] debounce_ticks;
		logic [TPS_W-1:0] ticks_per_second;
		logic [SEC_W-1:0] long_seconds;
	} cfg_t;

	typedef struct packed {
		logic [KEY_W-1:0] key_code;
		logic             short_press;
		logic             long_press;
		logic             wake_display;
		logic             display_blanked;
	} res_t;

endpackage

### hdl/kslp_in_if.sv
// Input channel of the keypad qualifier: valid/ready plus one scan beat.
// Depends on kslp_pkg.
interface kslp_in_if;
	import kslp_pkg::*;
	logic              valid;
	logic              ready;
	logic              tick_due;
	logic [LOW_W-1:0]  port_low_pins;
	logic [HIGH_W-1:0] port_high_pins;

	modport source(output valid, tick_due, port_low_pins, port_high_pins, input ready);
	modport sink(input valid, tick_due, port_low_pins, port_high_pins, output ready);
endinterface

### hdl/kslp_out_if.sv
// Output channel of the keypad qualifier: valid/ready plus one event beat.
// Depends on kslp_pkg.
interface kslp_out_if;
	import kslp_pkg::*;
	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] key_code;
	logic             short_press;
	logic             long_press;
	logic             wake_display;
	logic             display_blanked;

	modport source(output valid, key_code, short_press, long_press, wake_display,
		display_blanked, input ready);
	modport sink(input valid, key_code, short_press, long_press, wake_display,
		display_blanked, output ready);
endinterface

### hdl/kslp_decode.sv
// Key decoder: maps the active-low pin patterns to key codes 1..8, 0 otherwise.
// Depends on kslp_pkg.
module kslp_decode (
	input  logic [kslp_pkg::LOW_W-1:0]  port_low_pins,
	input  logic [kslp_pkg::HIGH_W-1:0] port_high_pins,
	output logic [kslp_pkg::KEY_W-1:0]  key
);
	import kslp_pkg::*;

	always_comb begin
		key = KEY_NONE;
		unique case (port_low_pins)
			PAT_K1: key = KEY_POWER;
			PAT_K2: key = KEY_2;
			PAT_K3: key = KEY_3;
			PAT_K4: key = KEY_4;
			PAT_K5: key = KEY_5;
			default: begin
				// low port takes priority; fall back to the high port
				unique case (port_high_pins)
					PAT_K6: key = KEY_6;
					PAT_K7: key = KEY_7;
					PAT_K8: key = KEY_8;
					default: key = KEY_NONE;
				endcase
			end
		endcase
	end
endmodule

### hdl/kslp_cfg_regs.sv
// Configuration register file of the keypad qualifier (write only).
// Depends on kslp_pkg.
module kslp_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [kslp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kslp_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output kslp_pkg::cfg_t                  cfg
);
	import kslp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks   <= DEB_RESET;
			cfg_q.ticks_per_second <= TPS_RESET;
			cfg_q.long_seconds     <= SEC_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IDX_DEBOUNCE: cfg_q.debounce_ticks   <= cfg_wdata[DEB_W-1:0];
				CFG_IDX_TPS:      cfg_q.ticks_per_second <= cfg_wdata[TPS_W-1:0];
				CFG_IDX_LONG:     cfg_q.long_seconds     <= cfg_wdata[SEC_W-1:0];
				default: ;  // unused index: drop the write
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

### hdl/kslp_core.sv
// Press qualifier state and next-state logic: debounce, short/long press, blanking.
// Depends on kslp_pkg.
module kslp_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic                        tick_due,
	input  logic [kslp_pkg::KEY_W-1:0]  key,
	input  kslp_pkg::cfg_t              cfg,
	output kslp_pkg::res_t              res
);
	import kslp_pkg::*;

	logic [KEY_W-1:0] last_key_q,  last_key_d;
	logic             active_q,    active_d;
	logic [TPS_W-1:0] tick_q,      tick_d;
	logic [SEC_W-1:0] sec_q,       sec_d;
	logic             long_rep_q,  long_rep_d;
	logic             blanked_q,   blanked_d;
	logic             woke_q,      woke_d;
	logic [TPS_W-1:0] deb_ext;

	assign deb_ext = {1'b0, cfg.debounce_ticks};

	always_comb begin
		last_key_d = last_key_q;
		active_d   = active_q;
		tick_d     = tick_q;
		sec_d      = sec_q;
		long_rep_d = long_rep_q;
		blanked_d  = blanked_q;
		woke_d     = woke_q;
		res.key_code     = KEY_NONE;
		res.short_press  = 1'b0;
		res.long_press   = 1'b0;
		res.wake_display = 1'b0;

		if (tick_due) begin
			if (last_key_q != key) begin
				if (key == KEY_NONE) begin
					active_d = 1'b0;
					// power key reports on release unless swallowed
					if (last_key_q == KEY_POWER) begin
						if (long_rep_q) begin
							long_rep_d = 1'b0;
						end else if (woke_q) begin
							woke_d = 1'b0;
						end else if (tick_q >= deb_ext || sec_q != '0) begin
							res.key_code    = KEY_POWER;
							res.short_press = 1'b1;
						end
					end
				end else begin
					active_d = 1'b1;
					tick_d   = '0;
					sec_d    = '0;
				end
				last_key_d = key;
			end

			if (active_d) begin
				if (tick_d == deb_ext) begin
					if (blanked_q) begin
						blanked_d        = 1'b0;
						woke_d           = 1'b1;
						active_d         = 1'b0;
						res.key_code     = last_key_d;
						res.wake_display = 1'b1;
					end else if (last_key_d != KEY_POWER) begin
						active_d        = 1'b0;
						res.key_code    = last_key_d;
						res.short_press = 1'b1;
					end
				end else if (tick_d == cfg.ticks_per_second) begin
					sec_d = sec_d + 1'b1;
					if (sec_d == cfg.long_seconds) begin
						long_rep_d     = 1'b1;
						sec_d          = '0;
						active_d       = 1'b0;
						res.key_code   = last_key_d;
						res.long_press = 1'b1;
						if (last_key_d == KEY_POWER) blanked_d = 1'b1;
					end else begin
						tick_d = '0;
					end
				end
				tick_d = tick_d + 1'b1;
			end
		end
		res.display_blanked = blanked_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_key_q <= KEY_NONE;
			active_q   <= 1'b0;
			tick_q     <= '0;
			sec_q      <= '0;
			long_rep_q <= 1'b0;
			blanked_q  <= 1'b0;
			woke_q     <= 1'b0;
		end else if (advance) begin
			last_key_q <= last_key_d;
			active_q   <= active_d;
			tick_q     <= tick_d;
			sec_q      <= sec_d;
			long_rep_q <= long_rep_d;
			blanked_q  <= blanked_d;
			woke_q     <= woke_d;
		end
	end
endmodule

### hdl/keypad_short_long_press_qualifier.sv
// Keypad short/long press qualifier, top level.
// An accepted beat sits in the input register, and its event is presented on out_ch
// once the beat moves into the result register. Throughput: one beat per cycle while
// out_ch keeps taking beats, set by the state update between the two registers.
// Reset: arst_n clears all press state and the display flag, and loads the default
// configuration (debounce 5, 100 ticks per second, 3 seconds).
// Depends on kslp_pkg, kslp_in_if, kslp_out_if, kslp_decode, kslp_cfg_regs, kslp_core.
module keypad_short_long_press_qualifier (
	input  logic                            clk,
	input  logic                            arst_n,
	kslp_in_if.sink                         in_ch,
	kslp_out_if.source                      out_ch,
	input  logic                            cfg_we,
	input  logic [kslp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kslp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import kslp_pkg::*;

	// Input register stage: one scan beat waiting for the state update
	logic              valid_s1;
	logic              tick_s1;
	logic [LOW_W-1:0]  low_s1;
	logic [HIGH_W-1:0] high_s1;

	// Result register stage
	logic valid_s2;
	res_t res_s2;

	logic             out_free;
	logic             advance;
	logic [KEY_W-1:0] key;
	cfg_t             cfg;
	res_t             res;

	// The result register frees up when empty or when its beat is taken this
	// cycle; the input register then drains into it, so a new beat can come in
	// every cycle while the sink keeps taking beats. A sink stall with both
	// registers full holds the input off for that cycle.
	assign out_free    = !valid_s2 || out_ch.ready;
	assign advance     = valid_s1 && out_free;
	assign in_ch.ready = !valid_s1 || out_free;

	kslp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	kslp_decode u_decode (
		.port_low_pins  (low_s1),
		.port_high_pins (high_s1),
		.key            (key)
	);

	// State commits only when the beat moves into the result register
	kslp_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.tick_due (tick_s1),
		.key      (key),
		.cfg      (cfg),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			tick_s1 <= in_ch.tick_due;
			low_s1  <= in_ch.port_low_pins;
			high_s1 <= in_ch.port_high_pins;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_ch.valid           = valid_s2;
	assign out_ch.key_code        = res_s2.key_code;
	assign out_ch.short_press     = res_s2.short_press;
	assign out_ch.long_press      = res_s2.long_press;
	assign out_ch.wake_display    = res_s2.wake_display;
	assign out_ch.display_blanked = res_s2.display_blanked;

	// A wake always leaves the display unblanked
	a_wake_unblanks: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.wake_display |-> !out_ch.display_blanked)
		else $error("wake event with display still blanked");

	// A long press of the power key blanks the display
	a_power_long_blanks: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.long_press && out_ch.key_code == KEY_POWER
		|-> out_ch.display_blanked)
		else $error("power key long press did not blank the display");

	// At most one event kind per beat, and any event names a key
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> $onehot0({out_ch.short_press, out_ch.long_press,
			out_ch.wake_display}) &&
			((out_ch.short_press || out_ch.long_press || out_ch.wake_display) ==
			(out_ch.key_code != KEY_NONE)))
		else $error("malformed event beat");

	// A beat held in the input register moves on once the result register frees
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_free |=> valid_s2)
		else $error("input register failed to drain");
endmodule
